[rtl/core/apq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm queue package
// Shared types, status codes and operation codes for the alarm queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SERVE  = 2'd2;
  localparam logic [1:0] OP_DONE   = 2'd3;

  localparam logic [2:0] ST_CRITICAL    = 3'd0;
  localparam logic [2:0] ST_OFFLINE     = 3'd1;
  localparam logic [2:0] ST_DEGRADED    = 3'd2;
  localparam logic [2:0] ST_WARNING     = 3'd3;
  localparam logic [2:0] ST_OPERATIONAL = 3'd4;
  localparam logic [2:0] ST_UNKNOWN     = 3'd5;

  localparam logic [1:0] OUT_NONE     = 2'd0;
  localparam logic [1:0] OUT_FILTERED = 2'd1;
  localparam logic [1:0] OUT_HELD     = 2'd2;
  localparam logic [1:0] OUT_QUEUED   = 2'd3;

  localparam logic [2:0] REG_HOLDOFF  = 3'd0;
  localparam logic [2:0] REG_MUTED    = 3'd1;
  localparam logic [2:0] REG_EN_CRIT  = 3'd2;
  localparam logic [2:0] REG_EN_DEGR  = 3'd3;
  localparam logic [2:0] REG_EN_WARN  = 3'd4;
  localparam logic [2:0] REG_EN_OFFL  = 3'd5;
  localparam logic [2:0] REG_WATCHDOG = 3'd6;

  // One queue entry.
  typedef struct packed {
    logic [3:0] source;
    logic [2:0] status;
    logic [6:0] health;
  } entry_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic       ins;     // insert the new entry
    logic       pop;     // shift everything one place to the head
    logic       rm;      // remove the entry of new_entry.source
    entry_t     new_entry;
  } cell_cmd_t;

  // Classify a colour into a status code.
  function automatic logic [2:0] classify(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    logic [7:0] drg;
    logic [7:0] dgb;
    drg = (r > g) ? r - g : g - r;
    dgb = (g > b) ? g - b : b - g;
    if (g >= 8'd200 && r < 8'd80 && b < 8'd80) return ST_OPERATIONAL;
    if (r >= 8'd200 && g < 8'd80 && b < 8'd80) return ST_CRITICAL;
    if (r >= 8'd200 && g >= 8'd200 && b < 8'd80) return ST_WARNING;
    if (r >= 8'd200 && g >= 8'd100 && b < 8'd80) return ST_DEGRADED;
    if (drg < 8'd30 && dgb < 8'd30 && r >= 8'd80 && r <= 8'd180) return ST_OFFLINE;
    return ST_UNKNOWN;
  endfunction

endpackage

[rtl/core/alarm_priority_queue_with_holdoff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm priority queue with holdoff
// Health updates are classified, filtered and held off per source; the
// survivors enter a sorted row of queue cells, served from the head.
//
// Usage: a request is taken when start is high and busy is low. Every
// request gives one result, shown for one cycle with done_o high. On
// acceptance the holdoff entry is read and the colour classified. For a
// queued health update, S_EXEC writes the table and runs a remove pass and
// S_INS then runs an insert pass; each pass shifts the cell chain one step.
// A new request can be taken at the edge that ends the done_o cycle.
// Results cannot be stalled.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) land at once and
// should only be made while idle. Reset clears the queue count, seen flags,
// busy state and time, and loads register defaults; no clearing pass runs.
// ----------------------------------------------------------------------------
module alarm_priority_queue_with_holdoff #(
  parameter int NUM_SOURCES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  source_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [6:0]  health_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic        alert_valid_o,
  output logic [3:0]  alert_source_o,
  output logic [2:0]  alert_status_o,
  output logic [6:0]  alert_health_o,
  output logic [1:0]  update_outcome_o,
  output logic [4:0]  queue_count_o,
  output logic        busy_res_o
);
  import apq_pkg::*;

  localparam int N  = (NUM_SOURCES < 16) ? NUM_SOURCES : 16;
  localparam int CW = $clog2(N + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_INS  = 2'd2;

  // Configuration registers.
  logic [31:0] holdoff_q, watchdog_q;
  logic        muted_q, en_crit_q, en_degr_q, en_warn_q, en_offl_q;

  // Control state.
  logic [1:0]  state_q;
  logic [31:0] now_q, bticks_q;
  logic        bflag_q;
  logic [CW-1:0] count_q;
  logic [N-1:0]  seen_q;
  logic [N-1:0]  valid_v;

  // Latched request.
  logic [1:0] op_q;
  logic [3:0] src_q;
  logic [2:0] st_q;
  logic [6:0] hp_q;
  logic [31:0] lat_q;
  logic [2:0]  lap_q;
  logic        inrange_q;

  // Holdoff table.
  logic [31:0] last_time_m [N];
  logic [2:0]  last_prio_m [N];

  logic [$clog2(N)-1:0] sidx;
  assign sidx = source_i[$clog2(N)-1:0];

  logic accept;
  assign accept = start && (state_q == S_IDLE);
  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_q <= last_time_m[sidx];
      lap_q <= last_prio_m[sidx];
    end
  end

  // Cell row.
  cell_cmd_t cmd;
  entry_t    entries [N];
  logic      shifts [N];
  logic      after [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    entry_t pe, ne;
    logic   pv, ps;
    assign pe = (i == 0) ? cmd.new_entry : entries[(i == 0) ? 0 : i-1];
    assign pv = (i == 0) ? 1'b0 : (!after[(i == 0) ? 0 : i-1] ? 1'b1 : 1'b0) &&
                valid_v[(i == 0) ? 0 : i-1];
    assign ps = (i == 0) ? 1'b0 : shifts[(i == 0) ? 0 : i-1];
    assign ne = (i == N-1) ? entries[i] : entries[(i == N-1) ? i : i+1];
    assign valid_v[i] = (CW'(i) < count_q);
    apq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .prev_valid_i (pv),
      .prev_entry_i (pe),
      .prev_shift_i (ps),
      .next_entry_i (ne),
      .valid_i      (valid_v[i]),
      .entry_o      (entries[i]),
      .shift_o      (shifts[i]),
      .next_valid_o (after[i])
    );
  end

  // Decision logic for the latched request.
  logic enabled, hold, present;
  logic [31:0] elapsed;
  always_comb begin
    unique case (st_q)
      ST_CRITICAL: enabled = en_crit_q;
      ST_OFFLINE:  enabled = en_offl_q;
      ST_DEGRADED: enabled = en_degr_q;
      ST_WARNING:  enabled = en_warn_q;
      default:     enabled = 1'b0;
    endcase
    elapsed = now_q - lat_q;
    hold = seen_q[src_q[$clog2(N)-1:0]] && !(st_q < lap_q) && (elapsed < holdoff_q);
    present = shifts[N-1];
  end

  logic queue_it, pop_it;
  assign queue_it = (state_q == S_EXEC) && (op_q == OP_UPDATE) && inrange_q
                    && enabled && !hold;
  assign pop_it = (state_q == S_EXEC) && (op_q == OP_SERVE) && !bflag_q
                  && (count_q != '0) && !muted_q;

  always_comb begin
    cmd.new_entry.source = src_q;
    cmd.new_entry.status = st_q;
    cmd.new_entry.health = hp_q;
    cmd.pop = pop_it;
    cmd.rm  = queue_it;
    cmd.ins = (state_q == S_INS);
  end

  // Watchdog next value.
  logic [31:0] bt_inc;
  assign bt_inc = (bticks_q != 32'hFFFF_FFFF) ? bticks_q + 32'd1 : bticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q  <= 32'd15000;
      watchdog_q <= 32'd30000;
      muted_q    <= 1'b0;
      en_crit_q  <= 1'b1;
      en_degr_q  <= 1'b1;
      en_warn_q  <= 1'b0;
      en_offl_q  <= 1'b1;
      state_q    <= S_IDLE;
      now_q      <= '0;
      bticks_q   <= '0;
      bflag_q    <= 1'b0;
      count_q    <= '0;
      seen_q     <= '0;
      done_o     <= 1'b0;
      op_q       <= OP_TICK;
      inrange_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_HOLDOFF:  holdoff_q  <= cfg_data_i;
          REG_MUTED:    muted_q    <= cfg_data_i[0];
          REG_EN_CRIT:  en_crit_q  <= cfg_data_i[0];
          REG_EN_DEGR:  en_degr_q  <= cfg_data_i[0];
          REG_EN_WARN:  en_warn_q  <= cfg_data_i[0];
          REG_EN_OFFL:  en_offl_q  <= cfg_data_i[0];
          REG_WATCHDOG: watchdog_q <= cfg_data_i;
          default: ;
        endcase
      end
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q      <= operation_i;
            inrange_q <= ({28'd0, source_i} < 32'(NUM_SOURCES));
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          done_o  <= 1'b1;
          unique case (op_q)
            OP_UPDATE: begin
              if (queue_it) begin
                seen_q[src_q[$clog2(N)-1:0]] <= 1'b1;
                if (present) count_q <= count_q - CW'(1);
                state_q <= S_INS;
                done_o  <= 1'b0;
              end
            end
            OP_TICK: begin
              now_q <= now_q + 32'd1;
              if (bflag_q) begin
                if (bt_inc >= watchdog_q) begin
                  bflag_q  <= 1'b0;
                  bticks_q <= '0;
                end else begin
                  bticks_q <= bt_inc;
                end
              end
            end
            OP_SERVE: begin
              if (pop_it) begin
                count_q  <= count_q - CW'(1);
                bflag_q  <= 1'b1;
                bticks_q <= '0;
              end
            end
            default: begin
              bflag_q  <= 1'b0;
              bticks_q <= '0;
            end
          endcase
        end
        S_INS: begin
          count_q <= count_q + CW'(1);
          state_q <= S_IDLE;
          done_o  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Holdoff table write and request payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= source_i;
      st_q  <= classify(red_i, green_i, blue_i);
      hp_q  <= (health_i > 7'd100) ? 7'd100 : health_i;
    end
    if (queue_it) begin
      last_time_m[src_q[$clog2(N)-1:0]] <= now_q;
      last_prio_m[src_q[$clog2(N)-1:0]] <= st_q;
    end
  end

  // Result registers.
  logic       res_av_q;
  entry_t     res_e_q;
  logic [1:0] res_oc_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      res_av_q <= pop_it;
      res_e_q  <= pop_it ? entries[0] : '0;
      if (op_q != OP_UPDATE || !inrange_q) res_oc_q <= OUT_NONE;
      else if (!enabled) res_oc_q <= OUT_FILTERED;
      else if (hold) res_oc_q <= OUT_HELD;
      else res_oc_q <= OUT_QUEUED;
    end
  end

  assign alert_valid_o    = res_av_q;
  assign alert_source_o   = res_e_q.source;
  assign alert_status_o   = res_e_q.status;
  assign alert_health_o   = res_e_q.health;
  assign update_outcome_o = res_oc_q;
  assign queue_count_o    = 5'(count_q);
  assign busy_res_o       = bflag_q;

endmodule

[rtl/core/apq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm queue cell
// One slot of the sorted queue. It looks at its neighbors and decides
// whether to keep, take the new entry, or shift from either side.
// ----------------------------------------------------------------------------
module apq_cell (
  input  logic              clk_i,
  input  apq_pkg::cell_cmd_t cmd_i,
  input  logic              prev_valid_i,
  input  apq_pkg::entry_t   prev_entry_i,
  input  logic              prev_shift_i,
  input  apq_pkg::entry_t   next_entry_i,
  input  logic              valid_i,
  output apq_pkg::entry_t   entry_o,
  output logic              shift_o,
  output logic              next_valid_o
);
  import apq_pkg::*;

  entry_t entry_q, entry_d;
  logic   here_after;

  // The new entry goes after this one if this one is equal or more urgent.
  assign here_after = valid_i && (entry_q.status <= cmd_i.new_entry.status)
                      && (entry_q.source != cmd_i.new_entry.source);

  // Shift state moving towards the tail: set once the removed source is passed.
  assign shift_o = prev_shift_i || (valid_i && entry_q.source == cmd_i.new_entry.source);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.pop) begin
      entry_d = next_entry_i;
    end else if (cmd_i.rm) begin
      if (shift_o) entry_d = next_entry_i;
    end else if (cmd_i.ins) begin
      if (!here_after) begin
        if (prev_valid_i) entry_d = prev_entry_i;
        else entry_d = cmd_i.new_entry;
      end
    end
  end

  assign next_valid_o = here_after;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[verif/alarm_priority_queue_with_holdoff_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm priority queue testbench
// Drives health updates, ticks, serve requests and completion notices in
// random bursts under several register settings. A tracker mirrors the
// classifier, holdoff table, sorted queue and busy watchdog, and checks
// every result field against its own prediction.
// ----------------------------------------------------------------------------
module alarm_priority_queue_with_holdoff_tb;
  import apq_pkg::*;

  // One result as seen on the result ports.
  typedef struct packed {
    logic       alert_valid;
    logic [3:0] alert_source;
    logic [2:0] alert_status;
    logic [6:0] alert_health;
    logic [1:0] update_outcome;
    logic [4:0] queue_count;
    logic       busy_res;
  } alarm_result_t;

  // Tracks the alarm state and the results still owed by the block.
  class alarm_queue_tracker;
    logic [31:0]   holdoff_ticks;
    logic          muted;
    logic [3:0]    enables;  // indexed by status code
    logic [31:0]   watchdog_ticks;
    logic [31:0]   now_ticks;
    logic          seen [16];
    logic [31:0]   last_time [16];
    logic [2:0]    last_status [16];
    entry_t        waiting [$];
    logic          announcing;
    logic [31:0]   busy_ticks;
    alarm_result_t expected_results [$];
    int            mismatches;

    function new();
      holdoff_ticks  = 32'd15000;
      muted          = 1'b0;
      enables        = 4'b0111;
      watchdog_ticks = 32'd30000;
      now_ticks      = '0;
      foreach (seen[i]) seen[i] = 1'b0;
      announcing     = 1'b0;
      busy_ticks     = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_HOLDOFF:  holdoff_ticks = val;
        REG_MUTED:    muted = val[0];
        REG_EN_CRIT:  enables[ST_CRITICAL] = val[0];
        REG_EN_DEGR:  enables[ST_DEGRADED] = val[0];
        REG_EN_WARN:  enables[ST_WARNING] = val[0];
        REG_EN_OFFL:  enables[ST_OFFLINE] = val[0];
        REG_WATCHDOG: watchdog_ticks = val;
        default: ;
      endcase
    endfunction

    function logic [2:0] color_status(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int drg;
      int dgb;
      drg = (r > g) ? r - g : g - r;
      dgb = (g > b) ? g - b : b - g;
      if (g >= 200 && r < 80 && b < 80) return ST_OPERATIONAL;
      if (r >= 200 && g < 80 && b < 80) return ST_CRITICAL;
      if (r >= 200 && g >= 200 && b < 80) return ST_WARNING;
      if (r >= 200 && g >= 100 && g <= 200 && b < 80) return ST_DEGRADED;
      if (drg < 30 && dgb < 30 && r >= 80 && r <= 180) return ST_OFFLINE;
      return ST_UNKNOWN;
    endfunction

    // Works out the result of one accepted request.
    function void note_request(logic [1:0] op, logic [3:0] src, logic [7:0] r,
                               logic [7:0] g, logic [7:0] b, logic [6:0] hp);
      alarm_result_t res;
      logic [2:0]    st;
      entry_t        e;
      int            pos;
      res = '0;
      if (hp > 7'd100) hp = 7'd100;
      case (op)
        OP_UPDATE: begin
          st = color_status(r, g, b);
          if (st > ST_WARNING || !enables[st]) begin
            res.update_outcome = OUT_FILTERED;
          end else if (seen[src] && !(st < last_status[src]) &&
                       (now_ticks - last_time[src]) < holdoff_ticks) begin
            res.update_outcome = OUT_HELD;
          end else begin
            seen[src] = 1'b1;
            last_time[src] = now_ticks;
            last_status[src] = st;
            // A source keeps one entry: drop the old one, then insert sorted.
            foreach (waiting[i]) begin
              if (waiting[i].source == src) begin
                waiting.delete(i);
                break;
              end
            end
            pos = 0;
            while (pos < waiting.size() && waiting[pos].status <= st) pos++;
            e.source = src;
            e.status = st;
            e.health = hp;
            waiting.insert(pos, e);
            res.update_outcome = OUT_QUEUED;
          end
        end
        OP_TICK: begin
          now_ticks = now_ticks + 1;
          if (announcing) begin
            if (busy_ticks != '1) busy_ticks++;
            if (busy_ticks >= watchdog_ticks) begin
              announcing = 1'b0;
              busy_ticks = '0;
            end
          end
        end
        OP_SERVE: begin
          if (!announcing && waiting.size() > 0 && !muted) begin
            e = waiting.pop_front();
            res.alert_valid  = 1'b1;
            res.alert_source = e.source;
            res.alert_status = e.status;
            res.alert_health = e.health;
            announcing = 1'b1;
            busy_ticks = '0;
          end
        end
        default: begin
          announcing = 1'b0;
          busy_ticks = '0;
        end
      endcase
      res.queue_count = 5'(waiting.size());
      res.busy_res = announcing;
      expected_results.push_back(res);
    endfunction

    // Compares one result with the oldest prediction.
    function void check_alert(alarm_result_t act);
      alarm_result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: %p", $realtime, act);
        mismatches++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (act.alert_valid !== exp_res.alert_valid ||
          act.alert_source !== exp_res.alert_source ||
          act.alert_status !== exp_res.alert_status ||
          act.alert_health !== exp_res.alert_health ||
          act.update_outcome !== exp_res.update_outcome ||
          act.queue_count !== exp_res.queue_count ||
          act.busy_res !== exp_res.busy_res) begin
        $display("%0t: expected %p, actual %p", $realtime, exp_res, act);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = OP_TICK;
  logic [3:0]  source_i = '0;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic [6:0]  health_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_HOLDOFF;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic        alert_valid_o;
  logic [3:0]  alert_source_o;
  logic [2:0]  alert_status_o;
  logic [6:0]  alert_health_o;
  logic [1:0]  update_outcome_o;
  logic [4:0]  queue_count_o;
  logic        busy_res_o;

  alarm_queue_tracker tracker = new();
  int idle_cycles = 0;
  localparam int IdleLimit = 2000;

  alarm_priority_queue_with_holdoff i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are taken at the rising edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (done_o) begin
      tracker.check_alert({alert_valid_o, alert_source_o, alert_status_o,
                           alert_health_o, update_outcome_o, queue_count_o,
                           busy_res_o});
    end
  end

  // Stall watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni && !(start && !busy) && !done_o) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Issues one request from a falling edge and returns at the falling edge
  // after it was accepted, with start still high.
  task automatic send(logic [1:0] op, logic [3:0] src, logic [7:0] r,
                      logic [7:0] g, logic [7:0] b, logic [6:0] hp);
    start = 1'b1;
    operation_i = op;
    source_i = src;
    red_i = r;
    green_i = g;
    blue_i = b;
    health_i = hp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_request(op, src, r, g, b, hp);
    @(negedge clk_i);
  endtask

  task automatic pause(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.write_reg(idx, val);
  endtask

  // Waits until every result has arrived and the block has settled.
  task automatic drain();
    start = 1'b0;
    while (tracker.expected_results.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Picks a colour from one of the status bands, or any colour at all.
  task automatic pick_color(output logic [7:0] r, output logic [7:0] g,
                            output logic [7:0] b);
    int base;
    case ($urandom_range(0, 6))
      0: begin
        r = 8'($urandom_range(200, 255));
        g = 8'($urandom_range(0, 79));
        b = 8'($urandom_range(0, 79));
      end
      1: begin
        base = $urandom_range(80, 180);
        r = 8'(base);
        g = 8'(base + int'($urandom_range(0, 58)) - 29);
        b = 8'(int'(g) + int'($urandom_range(0, 58)) - 29);
      end
      2: begin
        r = 8'($urandom_range(200, 255));
        g = 8'($urandom_range(100, 200));
        b = 8'($urandom_range(0, 79));
      end
      3: begin
        r = 8'($urandom_range(200, 255));
        g = 8'($urandom_range(200, 255));
        b = 8'($urandom_range(0, 79));
      end
      4: begin
        r = 8'($urandom_range(0, 79));
        g = 8'($urandom_range(200, 255));
        b = 8'($urandom_range(0, 79));
      end
      default: begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end
    endcase
  endtask

  task automatic random_requests(int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [6:0] hp;
    logic [1:0] op;
    int burst;
    int roll;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
      end
      burst--;
      roll = $urandom_range(0, 99);
      if (roll < 45) op = OP_UPDATE;
      else if (roll < 70) op = OP_TICK;
      else if (roll < 90) op = OP_SERVE;
      else op = OP_DONE;
      pick_color(r, g, b);
      hp = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100));
      send(op, 4'($urandom_range(0, 15)), r, g, b, hp);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: every status, saturated health, holdoff, requeue and busy rules.
    send(OP_UPDATE, 4'd0, 8'd255, 8'd0, 8'd0, 7'd127);
    send(OP_UPDATE, 4'd15, 8'd128, 8'd128, 8'd128, 7'd0);
    send(OP_UPDATE, 4'd3, 8'd255, 8'd150, 8'd0, 7'd100);
    send(OP_UPDATE, 4'd4, 8'd255, 8'd255, 8'd0, 7'd50);
    send(OP_UPDATE, 4'd5, 8'd0, 8'd255, 8'd0, 7'd60);
    send(OP_UPDATE, 4'd6, 8'd0, 8'd0, 8'd255, 7'd70);
    send(OP_UPDATE, 4'd0, 8'd200, 8'd79, 8'd79, 7'd1);
    send(OP_UPDATE, 4'd3, 8'd255, 8'd0, 8'd0, 7'd33);
    send(OP_UPDATE, 4'd15, 8'd180, 8'd200, 8'd190, 7'd101);
    send(OP_DONE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_SERVE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_SERVE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_DONE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_SERVE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_DONE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_SERVE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_DONE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_SERVE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    send(OP_SERVE, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0);
    drain();

    // Phases of register settings, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_HOLDOFF, 32'd0);
          write_reg(REG_WATCHDOG, 32'd1);
          write_reg(REG_EN_WARN, 32'd1);
        end
        1: begin
          write_reg(REG_HOLDOFF, 32'd3);
          write_reg(REG_WATCHDOG, 32'd4);
          write_reg(REG_EN_CRIT, $urandom);
          write_reg(REG_EN_DEGR, $urandom);
          write_reg(REG_EN_OFFL, $urandom);
        end
        2: begin
          write_reg(REG_MUTED, 32'd1);
          write_reg(REG_HOLDOFF, 32'd0);
          write_reg(REG_EN_CRIT, 32'd1);
          write_reg(REG_EN_DEGR, 32'd1);
          write_reg(REG_EN_OFFL, 32'd1);
        end
        3: begin
          write_reg(REG_MUTED, 32'd0);
          write_reg(REG_HOLDOFF, 32'hFFFF_FFFF);
          write_reg(REG_WATCHDOG, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(REG_HOLDOFF, 32'd20);
          write_reg(REG_WATCHDOG, 32'd0);
          write_reg(REG_EN_WARN, 32'd0);
          write_reg(REG_EN_OFFL, 32'd0);
        end
        default: begin
          write_reg(REG_HOLDOFF, $urandom_range(0, 12));
          write_reg(REG_WATCHDOG, $urandom_range(1, 6));
          write_reg(REG_EN_CRIT, 32'd0);
          write_reg(REG_EN_OFFL, 32'd1);
          write_reg(REG_EN_WARN, 32'd1);
        end
      endcase
      random_requests(315);
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
